/* rtl/lpt_pkg.sv */
package lpt_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int RANK_W  = SLOT_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int TBL_W   = 4;
  localparam int PAGE_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [ENTRIES-1:0] lpt_vec_t;
  typedef logic [SLOT_W-1:0]  lpt_slot_t;
  typedef logic [RANK_W-1:0]  lpt_rank_t;

  typedef struct packed {
    logic [TBL_W-1:0]  table_index;
    logic [PAGE_W-1:0] page_number;
    logic              page_kind;
  } lpt_in_t;

  typedef struct packed {
    logic              hit;
    logic [3:0]        slot;
    logic              evicted;
    logic [TBL_W-1:0]  evicted_table;
    logic [PAGE_W-1:0] evicted_page;
    logic              evicted_kind;
  } lpt_out_t;

  // per-request update sent to the tag and recency stores
  typedef struct packed {
    logic      en;
    logic      hit;
    lpt_slot_t slot;
  } lpt_upd_t;

  // lowest set bit index
  function automatic lpt_slot_t lpt_first(input lpt_vec_t v);
    lpt_slot_t r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/lpt_tags.sv */
module lpt_tags (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  lpt_pkg::lpt_upd_t upd,
  input  lpt_pkg::lpt_in_t  key,
  input  lpt_pkg::lpt_slot_t rd_slot,
  output lpt_pkg::lpt_vec_t match,
  output lpt_pkg::lpt_vec_t valid,
  output lpt_pkg::lpt_in_t  rd_tag
);
  import lpt_pkg::*;

  lpt_vec_t valid_r;
  lpt_in_t  tag_r [ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (upd.en && !upd.hit) begin
      valid_r[upd.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && !upd.hit) begin
      tag_r[upd.slot] <= key;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == key);
    end
  end

  assign valid  = valid_r;
  assign rd_tag = tag_r[rd_slot];

  // keys are unique among valid entries
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("lpt_tags: key matches more than one entry");

endmodule

/* rtl/lpt_recency.sv */
module lpt_recency (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  lpt_pkg::lpt_vec_t  valid,
  input  lpt_pkg::lpt_upd_t  upd,
  input  lpt_pkg::lpt_rank_t lru_rank,
  output lpt_pkg::lpt_vec_t  victim
);
  import lpt_pkg::*;

  lpt_rank_t rank_r   [ENTRIES];
  lpt_rank_t rank_nxt [ENTRIES];
  lpt_rank_t hit_rank;

  assign hit_rank = rank_r[upd.slot];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (upd.en) begin
        if (upd.slot == SLOT_W'(i)) begin
          rank_nxt[i] = '0;
        end else if (valid[i] && (!upd.hit || (rank_r[i] < hit_rank))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (!rst_n || clr) begin
        rank_r[i] <= '0;
      end else begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = valid[i] && (rank_r[i] == lru_rank);
    end
  end

  // ranks of valid entries are distinct, so at most one is oldest
  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(victim))
    else $error("lpt_recency: more than one oldest entry");

endmodule

/* rtl/lru_page_tag_cache.sv */
// Fully associative page tag cache with LRU replacement, 16 entries. One
// request can be started every cycle (busy stays low); its result word is
// shown on out_word with out_strobe high for one cycle: the request is
// registered, all tags are compared and the recency ranks updated in the
// same cycle, and the result is registered. The receiver
// cannot stall the result. A capacity write (cfg_ready is always high)
// clears every entry; write it only while no request is in flight.
module lru_page_tag_cache (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lpt_pkg::lpt_in_t          in_word,
  output logic                      out_strobe,
  output lpt_pkg::lpt_out_t         out_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lpt_pkg::CAP_W-1:0] cfg_data
);
  import lpt_pkg::*;

  logic             acc;
  logic             clr;
  logic             in_v_r;
  lpt_in_t          in_word_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             out_strobe_r;
  lpt_out_t         out_word_r;
  lpt_out_t         res;

  lpt_vec_t  match;
  lpt_vec_t  valid;
  lpt_vec_t  victim;
  lpt_slot_t victim_slot;
  lpt_slot_t slot;
  lpt_in_t   victim_tag;
  lpt_upd_t  upd;
  lpt_rank_t lru_rank;
  logic      hit;
  logic      full;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign clr       = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      in_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (clr) begin
      cap_r <= cfg_data;
    end
  end

  always_comb begin
    priority if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_r > CAP_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  assign hit         = |match;
  assign full        = (occ_r >= eff_cap);
  assign lru_rank    = RANK_W'(occ_r - 1'b1);
  assign victim_slot = lpt_first(victim);

  always_comb begin
    priority if (hit) begin
      slot = lpt_first(match);
    end else if (full) begin
      slot = victim_slot;
    end else begin
      slot = lpt_first(~valid);
    end
  end

  assign upd.en   = in_v_r;
  assign upd.hit  = hit;
  assign upd.slot = slot;

  lpt_tags u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .upd     (upd),
    .key     (in_word_r),
    .rd_slot (victim_slot),
    .match   (match),
    .valid   (valid),
    .rd_tag  (victim_tag)
  );

  lpt_recency u_recency (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .valid    (valid),
    .upd      (upd),
    .lru_rank (lru_rank),
    .victim   (victim)
  );

  always_comb begin
    occ_nxt = occ_r;
    if (in_v_r && !hit && !full) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_comb begin
    res.hit           = hit;
    res.slot          = 4'(slot);
    res.evicted       = !hit && full;
    res.evicted_table = '0;
    res.evicted_page  = '0;
    res.evicted_kind  = 1'b0;
    if (!hit && full) begin
      res.evicted_table = victim_tag.table_index;
      res.evicted_page  = victim_tag.page_number;
      res.evicted_kind  = victim_tag.page_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      out_word_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid) == int'(occ_r))
    else $error("lru_page_tag_cache: occupancy differs from valid count");

  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= eff_cap)
    else $error("lru_page_tag_cache: occupancy above capacity");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |=> out_strobe_r)
    else $error("lru_page_tag_cache: request produced no result word");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_word_r.evicted |-> !out_word_r.hit)
    else $error("lru_page_tag_cache: eviction reported on a hit");

endmodule

/* verif/lru_page_tag_cache_test.sv */
module lru_page_tag_cache_test;
  import lpt_pkg::*;

  class lru_tag_predictor;
    bit                tag_valid[ENTRIES];
    logic [TBL_W-1:0]  tag_tbl[ENTRIES];
    logic [PAGE_W-1:0] tag_page[ENTRIES];
    logic              tag_kind[ENTRIES];
    int                rank[ENTRIES];
    int                occupancy;
    int                capacity;
    lpt_out_t          expected_lookups[$];
    int                mismatches;
    int                lookups;
    int                hits;
    int                evictions;

    function new();
      capacity = 16;
      clear_tags();
    endfunction

    function void clear_tags();
      foreach (tag_valid[i]) begin
        tag_valid[i] = 1'b0;
        rank[i] = 0;
      end
      occupancy = 0;
    endfunction

    function void write_capacity(logic [CAP_W-1:0] v);
      capacity = v;
      clear_tags();
    endfunction

    function int eff_capacity();
      if (capacity == 0) begin
        return 1;
      end
      if (capacity > ENTRIES) begin
        return ENTRIES;
      end
      return capacity;
    endfunction

    function void age_below(int lim);
      foreach (tag_valid[i]) begin
        if (tag_valid[i] && rank[i] < lim) begin
          rank[i]++;
        end
      end
    endfunction

    function void note_request(lpt_in_t req);
      lpt_out_t exp_w;
      int found;
      int victim;
      int slot;
      exp_w = '0;
      found = -1;
      victim = -1;
      slot = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (found < 0 && tag_valid[i] && tag_tbl[i] == req.table_index &&
            tag_page[i] == req.page_number && tag_kind[i] == req.page_kind) begin
          found = i;
        end
      end
      if (found >= 0) begin
        age_below(rank[found]);
        rank[found] = 0;
        slot = found;
        exp_w.hit = 1'b1;
        hits++;
      end else begin
        if (occupancy >= eff_capacity()) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (tag_valid[i] && (victim < 0 || rank[i] > rank[victim])) begin
              victim = i;
            end
          end
          if (victim >= 0) begin
            exp_w.evicted = 1'b1;
            exp_w.evicted_table = tag_tbl[victim];
            exp_w.evicted_page = tag_page[victim];
            exp_w.evicted_kind = tag_kind[victim];
            tag_valid[victim] = 1'b0;
            occupancy--;
            slot = victim;
            evictions++;
          end
        end else begin
          // lowest free slot
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!tag_valid[i]) begin
              slot = i;
            end
          end
        end
        age_below(ENTRIES + 1);
        tag_valid[slot] = 1'b1;
        tag_tbl[slot] = req.table_index;
        tag_page[slot] = req.page_number;
        tag_kind[slot] = req.page_kind;
        rank[slot] = 0;
        occupancy++;
      end
      exp_w.slot = 4'(slot);
      lookups++;
      expected_lookups.insert(expected_lookups.size(), exp_w);
    endfunction

    task flag_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task cmp_field(string name, logic [PAGE_W-1:0] got_v, logic [PAGE_W-1:0] exp_v);
      if (got_v !== exp_v) begin
        flag_mismatch($sformatf("lookup %0d %s: got %h, expected %h",
                                lookups - expected_lookups.size(), name, got_v, exp_v));
      end
    endtask

    task check_lookup(lpt_out_t got);
      lpt_out_t exp_w;
      if (expected_lookups.size() == 0) begin
        flag_mismatch($sformatf("result word %h with no request pending", got));
        return;
      end
      exp_w = expected_lookups.pop_front();
      cmp_field("hit", PAGE_W'(got.hit), PAGE_W'(exp_w.hit));
      cmp_field("slot", PAGE_W'(got.slot), PAGE_W'(exp_w.slot));
      cmp_field("evicted", PAGE_W'(got.evicted), PAGE_W'(exp_w.evicted));
      cmp_field("evicted_table", PAGE_W'(got.evicted_table), PAGE_W'(exp_w.evicted_table));
      cmp_field("evicted_page", got.evicted_page, exp_w.evicted_page);
      cmp_field("evicted_kind", PAGE_W'(got.evicted_kind), PAGE_W'(exp_w.evicted_kind));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  lpt_in_t          in_word = '0;
  logic             cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic             busy;
  logic             out_strobe;
  lpt_out_t         out_word;
  logic             cfg_ready;

  lru_tag_predictor lru_model = new();
  int               gap_pct = 0;
  int               cap_writes = 0;

  lru_page_tag_cache uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      lru_model.check_lookup(out_word);
    end
  end

  task send_request(lpt_in_t req);
    int n;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    lru_model.note_request(req);
  endtask

  task lookup(logic [TBL_W-1:0] tbl, logic [PAGE_W-1:0] pg, logic kind);
    lpt_in_t req;
    req.table_index = tbl;
    req.page_number = pg;
    req.page_kind = kind;
    send_request(req);
  endtask

  task write_capacity_reg(logic [CAP_W-1:0] v);
    start <= 1'b0;
    while (lru_model.expected_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lru_model.write_capacity(v);
    cap_writes++;
  endtask

  function automatic lpt_in_t random_key();
    lpt_in_t k;
    k.table_index = TBL_W'($urandom_range(15));
    k.page_number = $urandom_range(1) ? PAGE_W'($urandom) : PAGE_W'($urandom_range(7));
    k.page_kind = 1'($urandom_range(1));
    return k;
  endfunction

  // mostly reuse of a working set sized near capacity, plus fresh keys and near misses
  task run_phase(int n_items, int pool_n, bit quiet);
    lpt_in_t pool[24];
    lpt_in_t req;
    int pick;
    for (int i = 0; i < pool_n; i++) begin
      pool[i] = random_key();
    end
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        if (quiet) begin
          gap_pct = 0;
        end
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        req = pool[$urandom_range(pool_n - 1)];
      end else if (pick < 85) begin
        req = random_key();
        pool[$urandom_range(pool_n - 1)] = req;
      end else begin
        req = pool[$urandom_range(pool_n - 1)];
        case ($urandom_range(2))
          0: req.page_kind = ~req.page_kind;
          1: req.page_number[$urandom_range(PAGE_W - 1)] ^= 1'b1;
          default: req.table_index[$urandom_range(TBL_W - 1)] ^= 1'b1;
        endcase
      end
      send_request(req);
    end
  endtask

  initial begin
    int caps[10];
    int eff;
    caps = '{1, 31, 17, 3, 16, 8, 0, 15, 0, 5};
    caps[8] = $urandom_range(31);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: extremes of the key fields, kind-only difference
    lookup(4'h0, 32'h0000_0000, 1'b0);
    lookup(4'hF, 32'hFFFF_FFFF, 1'b1);
    lookup(4'h0, 32'h0000_0000, 1'b1);
    lookup(4'h0, 32'h0000_0000, 1'b0);
    lookup(4'hF, 32'hFFFF_FFFF, 1'b1);
    lookup(4'hF, 32'hFFFF_FFFF, 1'b0);

    // two entries: fill, hit, LRU eviction order
    write_capacity_reg(5'd2);
    lookup(4'h1, 32'h0000_0001, 1'b0);
    lookup(4'h2, 32'h0000_0002, 1'b1);
    lookup(4'h1, 32'h0000_0001, 1'b0);
    lookup(4'h3, 32'h8000_0000, 1'b0);
    lookup(4'h2, 32'h0000_0002, 1'b1);
    lookup(4'h3, 32'h8000_0000, 1'b0);
    lookup(4'hF, 32'hFFFF_FFFF, 1'b1);

    // zero capacity behaves as one entry
    write_capacity_reg(5'd0);
    lookup(4'h4, 32'h0000_0005, 1'b1);
    lookup(4'h4, 32'h0000_0005, 1'b1);
    lookup(4'h4, 32'h0000_0006, 1'b1);
    lookup(4'hF, 32'h0000_0006, 1'b1);

    for (int p = 0; p < 10; p++) begin
      write_capacity_reg(CAP_W'(caps[p]));
      eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
      run_phase(150, eff + $urandom_range(0, 4), p == 9);
    end

    start <= 1'b0;
    while (lru_model.expected_lookups.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Covered %0d lookups across %0d capacity writes (zero, one, full, above range)",
             lru_model.lookups, cap_writes);
    $display("Saw %0d hits and %0d evictions", lru_model.hits, lru_model.evictions);
    if (lru_model.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for lookups to complete");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/lpt_pkg.sv
rtl/lpt_tags.sv
rtl/lpt_recency.sv
rtl/lru_page_tag_cache.sv
verif/lru_page_tag_cache_test.sv
